// ===== rtl/core/depq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// depq_pkg: shared types and constants for the double-ended priority queue
// Command codes, status codes, request/result structs, controller states.
// ----------------------------------------------------------------------------
package depq_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned OCC_W        = 7;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_POP_MIN = 2'd1,
    CMD_POP_MAX = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] removed_value;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, set up pointer
    logic step;      // one shift step of the store
    logic finish;    // write result, update count
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic shift_more;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/depq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// depq_ctrl: controller for the double-ended priority queue
// Sequences load, shift steps and result write for one request.
// ----------------------------------------------------------------------------
module depq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  output depq_pkg::dp_cmd_t       dp_cmd,
  input  wire depq_pkg::dp_stat_t dp_stat
);

  depq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= depq_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    busy       = 1'b1;
    case (state)
      depq_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          dp_cmd.load = 1'b1;
          state_next  = depq_pkg::S_SHIFT;
        end
      end
      depq_pkg::S_SHIFT: begin
        if (dp_stat.shift_more) dp_cmd.step = 1'b1;
        else begin
          dp_cmd.finish = 1'b1;
          state_next    = depq_pkg::S_DONE;
        end
      end
      depq_pkg::S_DONE: state_next = depq_pkg::S_IDLE;
      default:          state_next = depq_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/depq_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// depq_dp: datapath for the double-ended priority queue
// Sorted store in a one-port memory; insert and remove-min shift one entry
// at a time (a read, then a write).
// ----------------------------------------------------------------------------
module depq_dp #(
  parameter int unsigned CAPACITY = depq_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire depq_pkg::req_t     req,
  input  wire depq_pkg::dp_cmd_t  dp_cmd,
  output depq_pkg::dp_stat_t      dp_stat,
  output depq_pkg::res_t          res,
  output logic                    res_valid
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [depq_pkg::VAL_W-1:0] mem [CAPACITY];

  logic [CW-1:0]              count;
  logic [1:0]                 op;
  logic [depq_pkg::VAL_W-1:0] val;
  logic [1:0]                 status;
  logic [depq_pkg::VAL_W-1:0] removed;
  logic [CW-1:0]              ptr;       // hole (insert) or next address to read
  logic                       rd_pend;   // rdata holds a read not yet used
  logic [depq_pkg::VAL_W-1:0] rdata;
  logic [CW-1:0]              rd_addr_q; // address rdata came from
  logic                       active;    // memory walk in progress
  logic                       first;     // first read of a remove-min

  // insert walks ptr down from count; remove-min walks ptr up from 0
  logic ins_op, min_op;
  assign ins_op = (op == depq_pkg::CMD_INSERT);
  assign min_op = (op == depq_pkg::CMD_POP_MIN);

  logic ins_stop;
  assign ins_stop = rd_pend &&
    (($signed(rdata) <= $signed(val)));

  assign dp_stat.shift_more = active;

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else     res_valid <= dp_cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      active    <= 1'b0;
      rd_pend   <= 1'b0;
    end else if (dp_cmd.load) begin
      op      <= req.cmd;
      val     <= req.value;
      removed <= '0;
      status  <= depq_pkg::ST_OK;
      rd_pend <= 1'b0;
      first   <= 1'b1;
      active  <= 1'b0;
      case (depq_pkg::cmd_t'(req.cmd))
        depq_pkg::CMD_INSERT: begin
          if (count == CW'(CAPACITY)) status <= depq_pkg::ST_FULL;
          else begin
            ptr    <= count;   // slot count is the hole
            active <= 1'b1;
          end
        end
        depq_pkg::CMD_POP_MIN, depq_pkg::CMD_POP_MAX: begin
          if (count == '0) status <= depq_pkg::ST_EMPTY;
          else begin
            ptr    <= (req.cmd == depq_pkg::CMD_POP_MIN) ? '0 : count - 1'b1;
            active <= 1'b1;
          end
        end
        default: ;
      endcase
    end else if (dp_cmd.step) begin
      if (ins_op) begin
        // ptr is the hole; compare entry below, shift up or place
        if (!rd_pend) begin
          if (ptr == '0) begin
            mem[0] <= val;
            active <= 1'b0;
          end else begin
            rdata     <= mem[AW'(ptr - 1'b1)];
            rd_addr_q <= ptr - 1'b1;
            rd_pend   <= 1'b1;
          end
        end else begin
          rd_pend <= 1'b0;
          if (ins_stop) begin
            mem[AW'(ptr)] <= val;
            active        <= 1'b0;
          end else begin
            mem[AW'(ptr)] <= rdata;
            ptr           <= rd_addr_q;
          end
        end
      end else if (!min_op) begin
        // remove max: one read
        if (!rd_pend) begin
          rdata   <= mem[AW'(ptr)];
          rd_pend <= 1'b1;
        end else begin
          removed <= rdata;
          rd_pend <= 1'b0;
          active  <= 1'b0;
        end
      end else begin
        // remove min: read ptr, write to ptr-1
        if (!rd_pend) begin
          if (!first && ptr == count) active <= 1'b0;
          else begin
            rdata     <= mem[AW'(ptr)];
            rd_addr_q <= ptr;
            rd_pend   <= 1'b1;
          end
        end else begin
          rd_pend <= 1'b0;
          if (first) begin
            removed <= rdata;
            first   <= 1'b0;
          end else begin
            mem[AW'(rd_addr_q - 1'b1)] <= rdata;
          end
          ptr <= rd_addr_q + 1'b1;
        end
      end
    end else if (dp_cmd.finish) begin
      if (status == depq_pkg::ST_OK) begin
        if (ins_op) count <= count + 1'b1;
        else if (op != depq_pkg::CMD_NOP) count <= count - 1'b1;
      end
    end
  end

  always_comb begin
    res.removed_value = removed;
    res.status        = status;
    res.occupancy     = depq_pkg::OCC_W'(count);
  end

endmodule
`default_nettype wire

// ===== rtl/core/double_ended_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_priority_queue: bounded sorted multiset of signed values
// ----------------------------------------------------------------------------
// Usage:
//   Drive req and raise start while busy is low; the request is taken at
//   that edge. Commands: insert value, remove minimum, remove maximum, no-op.
//   One result per request appears on res for exactly one cycle with
//   done high; the receiver cannot stall it.
//   Values live in a sorted single-port memory of CAPACITY entries.
//   Insert shifts larger entries up one slot, remove-minimum shifts all
//   entries down; each moved entry is read, then written back.
//   busy stays high until the request completes (a full insert, an empty
//   removal or a no-op touches no memory); done comes in the last cycle of
//   busy, and the next request can be taken as soon as busy is low.
//   Reset (rst, synchronous) empties the store at once; no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_priority_queue #(
  parameter int unsigned CAPACITY = depq_pkg::CAPACITY_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire depq_pkg::req_t req,
  output logic                busy,
  output logic                done,
  output depq_pkg::res_t      res
);

  depq_pkg::dp_cmd_t  dp_cmd;
  depq_pkg::dp_stat_t dp_stat;
  logic               ctl_busy;

  depq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(ctl_busy),
    .dp_cmd(dp_cmd), .dp_stat(dp_stat)
  );

  depq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .req(req), .dp_cmd(dp_cmd), .dp_stat(dp_stat),
    .res(res), .res_valid(done)
  );

  assign busy = ctl_busy;

endmodule
`default_nettype wire

// ===== rtl/core/depq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// depq_checker: port-level checks for the double-ended priority queue
// ----------------------------------------------------------------------------
module depq_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done,
  input wire depq_pkg::res_t res
);

  a_no_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done outside busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> res.status != depq_pkg::ST_RSVD) else $error("bad status");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res.status != depq_pkg::ST_OK) |-> res.removed_value == '0)
    else $error("error result carries value");

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .res(res)
);
`default_nettype wire
